// File: rtl/core/telnet_option_negotiator_defines.svh
// ---------------------------------------------------------------------------
// Telnet option negotiator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATOR_DEFINES_SVH

// same-cycle implication
`define TNO_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("telnet negotiator assertion failed");

// next-cycle implication
`define TNO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("telnet negotiator assertion failed");

`endif

// File: rtl/core/tno_pkg.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator package
// Payload types, queue entry type, protocol constants and reply table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tno_pkg;

	localparam int TNO_QDEPTH = 4;

	localparam logic [7:0] T_IAC  = 8'd255;
	localparam logic [7:0] T_DONT = 8'd254;
	localparam logic [7:0] T_DO   = 8'd253;
	localparam logic [7:0] T_WONT = 8'd252;
	localparam logic [7:0] T_WILL = 8'd251;
	localparam logic [7:0] T_SB   = 8'd250;
	localparam logic [7:0] T_SE   = 8'd240;

	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_SGA   = 8'd3;
	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] TTYPE_IS   = 8'd0;
	localparam logic [7:0] TTYPE_SEND = 8'd1;

	localparam logic [3:0] IDX_LAST_THREE = 4'd2;
	localparam logic [3:0] IDX_LAST_TTYPE = 4'd11;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       segment_end;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       reply_last;
	} tx_item_t;

	typedef enum logic {
		REPLY_THREE = 1'b0,
		REPLY_TTYPE = 1'b1
	} reply_kind_t;

	typedef struct packed {
		reply_kind_t kind;
		logic [7:0]  verb;
		logic [7:0]  opt;
	} reply_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [7:0] ttype_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = T_IAC;
			4'd1:    b = T_SB;
			4'd2:    b = OPT_TTYPE;
			4'd3:    b = TTYPE_IS;
			4'd4:    b = 8'h50;
			4'd5:    b = 8'h49;
			4'd6:    b = 8'h43;
			4'd7:    b = 8'h4F;
			4'd8:    b = 8'h32;
			4'd9:    b = 8'h57;
			4'd10:   b = T_IAC;
			4'd11:   b = T_SE;
			default: b = T_SE;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] reply_byte_at(input reply_cmd_t cmd, input logic [3:0] idx);
		logic [7:0] b;
		if (cmd.kind == REPLY_TTYPE) begin
			b = ttype_byte(idx);
		end else begin
			unique case (idx)
				4'd0:    b = T_IAC;
				4'd1:    b = cmd.verb;
				default: b = cmd.opt;
			endcase
		end
		return b;
	endfunction

endpackage

// File: rtl/core/tno_front.sv
// ---------------------------------------------------------------------------
// Telnet negotiator front end
// Parses the received byte stream and queues reply commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tno_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  tno_pkg::rx_item_t  rx_item,
	input  tno_pkg::q_status_t q_status,
	output logic               push,
	output tno_pkg::reply_cmd_t push_cmd
);
	import tno_pkg::*;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'd0,
		PH_IAC    = 3'd1,
		PH_VERB   = 3'd2,
		PH_SBOPT  = 3'd3,
		PH_SBTT   = 3'd4,
		PH_SBBODY = 3'd5,
		PH_SBIAC  = 3'd6
	} phase_t;

	localparam logic [1:0] CMD_WILL = 2'd0;
	localparam logic [1:0] CMD_WONT = 2'd1;
	localparam logic [1:0] CMD_DO   = 2'd2;
	localparam logic [1:0] CMD_DONT = 2'd3;

	phase_t     phase_q, phase_d;
	logic [1:0] held_q, held_d;
	logic       accept;
	logic       want_push;
	logic [7:0] b;

	assign rx_stall = q_status.full;
	assign accept   = rx_valid && !rx_stall;
	assign b        = rx_item.rx_byte;
	assign push     = accept && want_push;

	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		want_push = 1'b0;
		push_cmd  = '{kind: REPLY_THREE, verb: T_WONT, opt: b};
		unique case (phase_q)
			PH_IAC: begin
				if (b >= T_WILL && b <= T_DONT) begin
					held_d  = b[1:0] + 2'd1;
					phase_d = PH_VERB;
				end else if (b == T_SB) begin
					phase_d = PH_SBOPT;
				end else begin
					phase_d = PH_NORMAL;
				end
			end
			PH_VERB: begin
				want_push = 1'b1;
				unique case (held_q)
					CMD_WILL: push_cmd.verb = (b == OPT_ECHO || b == OPT_SGA) ? T_DO : T_DONT;
					CMD_WONT: push_cmd.verb = T_DONT;
					CMD_DO:   push_cmd.verb = (b == OPT_SGA || b == OPT_TTYPE) ? T_WILL : T_WONT;
					CMD_DONT: push_cmd.verb = T_WONT;
				endcase
				phase_d = PH_NORMAL;
			end
			PH_SBOPT: begin
				if (b == OPT_TTYPE) phase_d = PH_SBTT;
				else if (b == T_IAC) phase_d = PH_SBIAC;
				else phase_d = PH_SBBODY;
			end
			PH_SBTT: begin
				if (b == TTYPE_SEND) begin
					want_push     = 1'b1;
					push_cmd.kind = REPLY_TTYPE;
					phase_d       = PH_SBBODY;
				end else if (b == T_IAC) begin
					phase_d = PH_SBIAC;
				end else begin
					phase_d = PH_SBBODY;
				end
			end
			PH_SBBODY: begin
				if (b == T_IAC) phase_d = PH_SBIAC;
			end
			PH_SBIAC: begin
				phase_d = (b == T_SE) ? PH_NORMAL : PH_SBBODY;
			end
			default: begin
				phase_d = (b == T_IAC) ? PH_IAC : PH_NORMAL;
			end
		endcase
		if (rx_item.segment_end) begin
			phase_d = PH_NORMAL;
			held_d  = CMD_WILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			held_q  <= CMD_WILL;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

// File: rtl/core/tno_queue.sv
// ---------------------------------------------------------------------------
// Telnet negotiator command queue
// Small FIFO of reply commands between parser and reply sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "telnet_option_negotiator_defines.svh"

module tno_queue #(
	parameter int DEPTH = tno_pkg::TNO_QDEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tno_pkg::reply_cmd_t push_cmd,
	input  logic                pop,
	output tno_pkg::reply_cmd_t head,
	output tno_pkg::q_status_t  q_status
);
	import tno_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	reply_cmd_t    mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign q_status.empty = (cnt_q == '0);
	assign q_status.full  = (cnt_q == CNT_FULL);
	assign head           = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	`TNO_ASSERT_IMPL(a_no_overflow, push, !q_status.full)
	`TNO_ASSERT_IMPL(a_no_underflow, pop, !q_status.empty)
	`TNO_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_FULL)

endmodule

// File: rtl/core/tno_back.sv
// ---------------------------------------------------------------------------
// Telnet negotiator reply sequencer
// Expands queued commands into reply bytes behind an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "telnet_option_negotiator_defines.svh"

module tno_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tno_pkg::reply_cmd_t head,
	input  tno_pkg::q_status_t  q_status,
	output logic                pop,
	output logic                tx_valid,
	input  logic                tx_stall,
	output tno_pkg::tx_item_t   tx_item
);
	import tno_pkg::*;

	reply_cmd_t cur_q;
	logic [3:0] idx_q;
	logic       busy_q;
	logic       valid_q;
	tx_item_t   item_q;
	logic       advance;
	logic [3:0] last_idx;
	logic       at_last;

	assign tx_valid = valid_q;
	assign tx_item  = item_q;
	assign advance  = !valid_q || !tx_stall;
	assign pop      = advance && !busy_q && !q_status.empty;
	assign last_idx = (cur_q.kind == REPLY_TTYPE) ? IDX_LAST_TTYPE : IDX_LAST_THREE;
	assign at_last  = (idx_q == last_idx);

	always_ff @(posedge clk) begin
		if (advance) begin
			if (busy_q) begin
				item_q.reply_byte <= reply_byte_at(cur_q, idx_q);
				item_q.reply_last <= at_last;
			end else begin
				item_q.reply_byte <= T_IAC;
				item_q.reply_last <= 1'b0;
			end
			if (pop) cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			if (busy_q) begin
				valid_q <= 1'b1;
				if (at_last) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end else if (pop) begin
				valid_q <= 1'b1;
				busy_q  <= 1'b1;
				idx_q   <= 4'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	`TNO_ASSERT_IMPL(a_busy_idx, busy_q, idx_q != 4'd0 && idx_q <= last_idx)
	`TNO_ASSERT_NEXT(a_pop_starts, pop, busy_q && idx_q == 4'd1)
	`TNO_ASSERT_IMPL(a_no_pop_busy, busy_q, !pop)

endmodule

// File: rtl/core/telnet_option_negotiator.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator
// Client-side option negotiation over a received Telnet byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid/rx_stall/rx_item) takes one received byte per
//   transfer, with segment_end set on the last byte of a receive segment.
//   tx channel (tx_valid/tx_stall/tx_item) gives reply bytes; reply_last
//   marks the final byte of each three- or twelve-byte reply.
//   Throughput: one received byte per cycle while the command queue has
//   room; replies leave at one byte per cycle while tx_stall is low.
//   The first reply byte follows the byte that completes the request
//   through the queue write, then the output register.
//   When the receiver holds tx_stall, the output register holds its byte
//   and the queue fills; rx_stall rises only once the queue is full.
//   Reset (arst_n low) returns the parser to normal text, clears the queue
//   and drops tx_valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_option_negotiator #(
	parameter int QDEPTH = tno_pkg::TNO_QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  tno_pkg::rx_item_t rx_item,
	output logic              tx_valid,
	input  logic              tx_stall,
	output tno_pkg::tx_item_t tx_item
);
	import tno_pkg::*;

	q_status_t  q_status;
	logic       push;
	logic       pop;
	reply_cmd_t push_cmd;
	reply_cmd_t head;

	tno_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_item  (rx_item),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tno_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	tno_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx_item  (tx_item)
	);

endmodule

// File: tb/telnet_option_negotiator_tb.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator testbench
// Feeds received Telnet bytes through the rx channel and compares each reply
// byte on the tx channel against a local model of the client negotiator.
// Directed tests cover each verb, terminal-type SEND, escapes and segment
// ends. A random stream of mostly well-formed commands follows. The sender
// works in bursts and the receiver stalls on patterns of its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_option_negotiator_tb;

	import tno_pkg::*;

	localparam int RANDOM_ITEMS   = 350;
	localparam int PAUSE_EVERY    = 120;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [12*8-1:0] TTYPE_ANSWER = {
		T_IAC, T_SB, OPT_TTYPE, TTYPE_IS, 8'h50, 8'h49,
		8'h43, 8'h4F, 8'h32, 8'h57, T_IAC, T_SE
	};

	typedef enum logic [2:0] {
		RX_TEXT, RX_CMD, RX_OPTION, RX_SUB_OPT, RX_SUB_TTYPE, RX_SUB_BODY, RX_SUB_IAC
	} rx_phase_t;

	typedef enum logic [1:0] {
		VERB_WILL, VERB_WONT, VERB_DO, VERB_DONT
	} verb_t;

	logic     clk      = 1'b0;
	logic     arst_n   = 1'b0;
	logic     rx_valid = 1'b0;
	logic     rx_stall;
	rx_item_t rx_item  = '0;
	logic     tx_valid;
	logic     tx_stall = 1'b0;
	tx_item_t tx_item;

	rx_phase_t rx_phase     = RX_TEXT;
	verb_t     pending_verb = VERB_WILL;
	tx_item_t  pending_replies[$];
	int        mismatches   = 0;
	int        items_sent   = 0;
	int        burst_left   = 0;

	telnet_option_negotiator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_item  (rx_item),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx_item  (tx_item)
	);

	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	function automatic tx_item_t make_reply(input logic [7:0] b, input logic last);
		tx_item_t r;
		r.reply_byte = b;
		r.reply_last = last;
		return r;
	endfunction

	function automatic void push_answer(input logic [7:0] verb, input logic [7:0] opt);
		pending_replies.push_back(make_reply(T_IAC, 1'b0));
		pending_replies.push_back(make_reply(verb, 1'b0));
		pending_replies.push_back(make_reply(opt, 1'b1));
	endfunction

	function automatic void track_rx_byte(input logic [7:0] b, input logic seg);
		logic [7:0] code;
		int k;
		case (rx_phase)
			RX_CMD: begin
				if (b >= T_WILL && b <= T_DONT) begin
					code = b - T_WILL;
					pending_verb = verb_t'(code[1:0]);
					rx_phase = RX_OPTION;
				end else if (b == T_SB) begin
					rx_phase = RX_SUB_OPT;
				end else begin
					rx_phase = RX_TEXT;
				end
			end
			RX_OPTION: begin
				case (pending_verb)
					VERB_WILL: push_answer((b == OPT_ECHO || b == OPT_SGA) ? T_DO : T_DONT, b);
					VERB_WONT: push_answer(T_DONT, b);
					VERB_DO:   push_answer((b == OPT_SGA || b == OPT_TTYPE) ? T_WILL : T_WONT, b);
					default:   push_answer(T_WONT, b);
				endcase
				rx_phase = RX_TEXT;
			end
			RX_SUB_OPT: begin
				if (b == OPT_TTYPE) rx_phase = RX_SUB_TTYPE;
				else if (b == T_IAC) rx_phase = RX_SUB_IAC;
				else rx_phase = RX_SUB_BODY;
			end
			RX_SUB_TTYPE: begin
				if (b == TTYPE_SEND) begin
					for (k = 0; k < 12; k++) begin
						pending_replies.push_back(make_reply(TTYPE_ANSWER[(11 - k) * 8 +: 8], k == 11));
					end
					rx_phase = RX_SUB_BODY;
				end else if (b == T_IAC) begin
					rx_phase = RX_SUB_IAC;
				end else begin
					rx_phase = RX_SUB_BODY;
				end
			end
			RX_SUB_BODY: begin
				if (b == T_IAC) rx_phase = RX_SUB_IAC;
			end
			RX_SUB_IAC: begin
				rx_phase = (b == T_SE) ? RX_TEXT : RX_SUB_BODY;
			end
			default: begin
				rx_phase = (b == T_IAC) ? RX_CMD : RX_TEXT;
			end
		endcase
		if (seg) begin
			rx_phase = RX_TEXT;
			pending_verb = VERB_WILL;
		end
	endfunction

	task automatic send_rx(input logic [7:0] b, input logic seg);
		rx_item_t item;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				rx_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		item.rx_byte = b;
		item.segment_end = seg;
		rx_valid <= 1'b1;
		rx_item <= item;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		track_rx_byte(b, seg);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_rand(input logic [7:0] b);
		send_rx(b, $urandom_range(0, 23) == 0);
	endtask

	task automatic wait_replies_drained();
		rx_valid <= 1'b0;
		@(negedge clk);
		while (pending_replies.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_option();
		logic [7:0] opt;
		case ($urandom_range(0, 5))
			0:       opt = OPT_ECHO;
			1:       opt = OPT_SGA;
			2:       opt = OPT_TTYPE;
			3:       opt = 8'd0;
			4:       opt = 8'd255;
			default: opt = 8'($urandom_range(0, 255));
		endcase
		return opt;
	endfunction

	task automatic send_sub_body();
		int n;
		int k;
		n = $urandom_range(0, 4);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: begin
					send_rand(T_IAC);
					send_rand(T_IAC);
				end
				1: begin
					send_rand(T_IAC);
					send_rand(8'($urandom_range(0, 239)));
				end
				default: send_rand(8'($urandom_range(0, 254)));
			endcase
		end
		send_rand(T_IAC);
		send_rand(T_SE);
	endtask

	task automatic test_option_replies();
		send_rx(T_IAC, 1'b0); send_rx(T_DO, 1'b0);   send_rx(OPT_SGA, 1'b0);
		send_rx(T_IAC, 1'b0); send_rx(T_DO, 1'b0);   send_rx(8'd255, 1'b0);
		send_rx(T_IAC, 1'b0); send_rx(T_WILL, 1'b0); send_rx(OPT_ECHO, 1'b0);
		send_rx(T_IAC, 1'b0); send_rx(T_WILL, 1'b0); send_rx(8'd0, 1'b0);
		send_rx(T_IAC, 1'b0); send_rx(T_WONT, 1'b0); send_rx(OPT_TTYPE, 1'b0);
		send_rx(T_IAC, 1'b0); send_rx(T_DONT, 1'b0); send_rx(OPT_SGA, 1'b0);
	endtask

	task automatic test_ttype_subneg();
		send_rx(T_IAC, 1'b0);
		send_rx(T_SB, 1'b0);
		send_rx(OPT_TTYPE, 1'b0);
		send_rx(TTYPE_SEND, 1'b0);
		send_rx(T_IAC, 1'b0);
		send_rx(T_SE, 1'b0);
	endtask

	task automatic test_escaped_iac();
		send_rx(T_IAC, 1'b0);
		send_rx(T_IAC, 1'b0);
	endtask

	task automatic test_segment_cut();
		send_rx(T_IAC, 1'b1);
		send_rx(T_IAC, 1'b0);
		send_rx(T_WILL, 1'b1);
		send_rx(OPT_SGA, 1'b0);
	endtask

	task automatic test_random_stream();
		int start;
		int next_pause;
		int n;
		int k;
		start = items_sent;
		next_pause = PAUSE_EVERY;
		while (items_sent - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					send_rand(T_IAC);
					send_rand(8'(T_WILL + $urandom_range(0, 3)));
					send_rand(pick_option());
				end
				4, 5: begin
					send_rand(T_IAC);
					send_rand(T_SB);
					send_rand(OPT_TTYPE);
					send_rand(TTYPE_SEND);
					send_sub_body();
				end
				6: begin
					send_rand(T_IAC);
					send_rand(T_SB);
					send_rand(8'($urandom_range(0, 255)));
					send_rand(8'($urandom_range(0, 255)));
					send_sub_body();
				end
				7: begin
					n = $urandom_range(1, 4);
					for (k = 0; k < n; k++) send_rand(8'($urandom_range(0, 254)));
				end
				8: begin
					send_rand(T_IAC);
					send_rand(8'($urandom_range(0, 255)));
				end
				default: begin
					n = $urandom_range(1, 3);
					for (k = 0; k < n; k++) send_rand(8'($urandom_range(0, 255)));
				end
			endcase
			if (items_sent - start >= next_pause) begin
				wait_replies_drained();
				next_pause += PAUSE_EVERY;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_option_replies();
		test_ttype_subneg();
		test_escaped_iac();
		test_segment_cut();
		wait_replies_drained();
		test_random_stream();
		wait_replies_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("telnet_option_negotiator_tb OK");
		end else begin
			$display("telnet_option_negotiator_tb NOT OK");
		end
		$finish;
	end

	initial begin
		int mode;
		int span;
		int hold_len;
		int k;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 80);
			hold_len = $urandom_range(1, 20);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0:       tx_stall <= 1'b0;
					1:       tx_stall <= ($urandom_range(0, 3) == 0);
					2:       tx_stall <= (k < hold_len);
					default: tx_stall <= ((k % 8) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		tx_item_t want;
		if (arst_n && tx_valid && !tx_stall) begin
			if (pending_replies.size() == 0) begin
				$display("%0t unexpected reply transfer: byte %02h last %0b",
					$time, tx_item.reply_byte, tx_item.reply_last);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				if (tx_item.reply_byte !== want.reply_byte) begin
					$display("%0t reply_byte mismatch: expected %02h, actual %02h",
						$time, want.reply_byte, tx_item.reply_byte);
					mismatches++;
				end
				if (tx_item.reply_last !== want.reply_last) begin
					$display("%0t reply_last mismatch: expected %0b, actual %0b",
						$time, want.reply_last, tx_item.reply_last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rx_valid && !rx_stall) || (tx_valid && !tx_stall)) quiet = 0;
			else quiet++;
		end
		$display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("telnet_option_negotiator_tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tno_pkg.sv
rtl/core/tno_front.sv
rtl/core/tno_queue.sv
rtl/core/tno_back.sv
rtl/core/telnet_option_negotiator.sv
tb/telnet_option_negotiator_tb.sv
